### rtl/fcht_pkg.sv
`timescale 1ns / 1ps

package fcht_pkg;

    // Fixed field widths of the request and response
    localparam int SN_W    = 19;
    localparam int FM_W    = 5;
    localparam int SA_W    = 8;
    localparam int TS_W    = 32;
    localparam int RI_W    = 5;
    localparam int SLOT_W  = 5;
    localparam int CNT_W   = 6;
    localparam int OCC_O_W = 16;

    typedef enum logic [1:0] {
        OP_STORE   = 2'd0,
        OP_CLR_ACT = 2'd1,
        OP_CLR_ALL = 2'd2,
        OP_READ    = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_UPDATED  = 3'd0,
        ST_INSERTED = 3'd1,
        ST_REPLACED = 3'd2,
        ST_CLR_ACT  = 3'd3,
        ST_CLR_ALL  = 3'd4,
        ST_READ     = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_READ,
        S_RESULT
    } t_state;

    typedef struct packed {
        t_op               opcode;
        logic [SN_W-1:0]   suspect_number;
        logic [FM_W-1:0]   failure_mode;
        logic [SA_W-1:0]   source_addr;
        logic [TS_W-1:0]   time_stamp;
        logic              active_in;
        logic [RI_W-1:0]   read_index;
    } t_req;

    typedef struct packed {
        t_status            status;
        logic [SLOT_W-1:0]  slot;
        logic [CNT_W-1:0]   used_entries;
        logic [CNT_W-1:0]   active_entries;
        logic [SN_W-1:0]    rd_suspect_number;
        logic [FM_W-1:0]    rd_failure_mode;
        logic [SA_W-1:0]    rd_source_addr;
        logic [TS_W-1:0]    rd_first_seen;
        logic [TS_W-1:0]    rd_last_seen;
        logic [OCC_O_W-1:0] rd_occurrences;
        logic               rd_active;
    } t_rsp;

endpackage

### rtl/fcht_if.sv
`timescale 1ns / 1ps

interface fcht_req_if;
    logic            valid;
    logic            ready;
    fcht_pkg::t_req  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface fcht_rsp_if;
    logic            valid;
    logic            ready;
    fcht_pkg::t_rsp  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### rtl/fault_code_history_table.sv
`timescale 1ns / 1ps

// Channel   Dir  Modport        Carries
// i_req     in   fcht_req_if    opcode, record key, time stamp, active flag, read index
// o_rsp     out  fcht_rsp_if    status, slot, used/active counts, read-back fields
//
// Store: scans the used entries one per cycle through the record RAM port, up to the
// first key match, else all used ones (none on an empty table), then writes the entry.
// Read: one RAM read. Clear active / clear all take effect at accept. Each operation
// then passes through the result state. One request in flight.
// Reset clears the fill level, active flags and counts; RAM contents are not swept,
// since entries at or beyond the fill level are treated as zero.
// A finished result waits in the output register; the next request is taken
// meanwhile and stalls only at its own result if the register is still full.
module fault_code_history_table #(
    parameter int TABLE_DEPTH      = 32,
    parameter int OCCURRENCE_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fcht_req_if.sink    i_req,
    fcht_rsp_if.source  o_rsp
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int OW = OCCURRENCE_WIDTH;
    localparam int RW = fcht_pkg::SN_W + fcht_pkg::FM_W + fcht_pkg::SA_W
                      + 2 * fcht_pkg::TS_W + OW;
    localparam logic [OW-1:0] OCC_MAX = {OW{1'b1}};
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    fcht_pkg::t_state r_state, n_state;
    fcht_pkg::t_req   r_req;
    fcht_pkg::t_rsp   r_res;          // status, slot and read-back of current request
    fcht_pkg::t_rsp   r_out;
    logic             r_out_valid;

    logic [CW-1:0]          r_fill;        // used entries, filled in index order
    logic [CW-1:0]          r_act_cnt;     // running count of set active flags
    logic [TABLE_DEPTH-1:0] r_active;      // active flags; zero beyond fill level

    // scan pipeline: issue index, then compare in the next cycle
    logic [CW-1:0]              r_scan_idx;
    logic                       r_chk_valid;
    logic [IW-1:0]              r_chk_idx;
    logic                       r_hit;
    logic [IW-1:0]              r_hit_idx;
    logic [fcht_pkg::TS_W-1:0]  r_hit_first;
    logic [OW-1:0]              r_hit_occ;
    logic [fcht_pkg::TS_W-1:0]  r_min_last;    // oldest last-seen, lowest index on tie
    logic [IW-1:0]              r_min_idx;

    // ------------------------------------------------------------------
    // Record RAM
    // ------------------------------------------------------------------
    logic          w_we, w_re;
    logic [IW-1:0] w_waddr, w_raddr;
    logic [RW-1:0] w_wdata, w_rdata;

    logic [fcht_pkg::SN_W-1:0] m_sn;
    logic [fcht_pkg::FM_W-1:0] m_fm;
    logic [fcht_pkg::SA_W-1:0] m_sa;
    logic [fcht_pkg::TS_W-1:0] m_first;
    logic [fcht_pkg::TS_W-1:0] m_last;
    logic [OW-1:0]             m_occ;

    assign {m_sn, m_fm, m_sa, m_first, m_last, m_occ} = w_rdata;

    fcht_ram #(
        .WIDTH (RW),
        .DEPTH (TABLE_DEPTH)
    ) u_rec_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // ------------------------------------------------------------------
    // Decode
    // ------------------------------------------------------------------
    logic w_accept;
    logic w_key_hit;
    logic w_scan_done;
    logic w_out_free;
    logic w_in_ri_used;    // read index of incoming request names a used entry
    logic w_ri_used;       // same, for the held request

    fcht_pkg::t_rsp w_res_init;    // response template set up at accept
    fcht_pkg::t_rsp w_out;         // response with the counts filled in

    assign i_req.ready = (r_state == fcht_pkg::S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_out_free  = !r_out_valid || o_rsp.ready;

    assign w_in_ri_used = 32'(i_req.payload.read_index) < 32'(r_fill);
    assign w_ri_used    = 32'(r_req.read_index) < 32'(r_fill);

    assign w_key_hit = (m_sn == r_req.suspect_number) && (m_fm == r_req.failure_mode)
                    && (m_sa == r_req.source_addr);
    assign w_scan_done = r_chk_valid
                      && (w_key_hit || (CW'(r_chk_idx) == r_fill - CW'(1)));

    always_comb begin
        w_res_init = '0;
        if (i_req.payload.opcode == fcht_pkg::OP_CLR_ACT) begin
            w_res_init.status = fcht_pkg::ST_CLR_ACT;
        end
        if (i_req.payload.opcode == fcht_pkg::OP_CLR_ALL) begin
            w_res_init.status = fcht_pkg::ST_CLR_ALL;
        end
    end

    always_comb begin
        w_out                = r_res;
        w_out.used_entries   = fcht_pkg::CNT_W'(r_fill);
        w_out.active_entries = fcht_pkg::CNT_W'(r_act_cnt);
    end

    // write-back decision
    logic [IW-1:0]           w_slot;
    fcht_pkg::t_status       w_status;
    logic [OW-1:0]           w_occ_next;

    always_comb begin
        w_occ_next = (r_hit_occ == OCC_MAX) ? r_hit_occ : r_hit_occ + OW'(1);
        priority if (r_hit) begin
            w_slot   = r_hit_idx;
            w_status = fcht_pkg::ST_UPDATED;
        end else if (r_fill < DEPTH_C) begin
            w_slot   = IW'(r_fill);
            w_status = fcht_pkg::ST_INSERTED;
        end else begin
            w_slot   = r_min_idx;
            w_status = fcht_pkg::ST_REPLACED;
        end
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fcht_pkg::S_IDLE: begin
                if (w_accept) begin
                    unique case (i_req.payload.opcode)
                        fcht_pkg::OP_STORE:
                            n_state = (r_fill == '0) ? fcht_pkg::S_WRITE : fcht_pkg::S_SCAN;
                        fcht_pkg::OP_CLR_ACT,
                        fcht_pkg::OP_CLR_ALL: n_state = fcht_pkg::S_RESULT;
                        fcht_pkg::OP_READ:    n_state = fcht_pkg::S_READ;
                    endcase
                end
            end
            fcht_pkg::S_SCAN:   if (w_scan_done) n_state = fcht_pkg::S_WRITE;
            fcht_pkg::S_WRITE:  n_state = fcht_pkg::S_RESULT;
            fcht_pkg::S_READ:   n_state = fcht_pkg::S_RESULT;
            fcht_pkg::S_RESULT: if (w_out_free) n_state = fcht_pkg::S_IDLE;
            default:            n_state = fcht_pkg::S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // RAM port control
    // ------------------------------------------------------------------
    always_comb begin
        w_re    = 1'b0;
        w_raddr = '0;
        w_we    = 1'b0;
        w_waddr = w_slot;
        w_wdata = {r_req.suspect_number, r_req.failure_mode, r_req.source_addr,
                   r_req.time_stamp, r_req.time_stamp, OW'(1)};
        unique case (r_state)
            fcht_pkg::S_IDLE: begin
                if (w_accept && (i_req.payload.opcode == fcht_pkg::OP_READ)) begin
                    w_re    = w_in_ri_used;
                    w_raddr = IW'(i_req.payload.read_index);
                end
            end
            fcht_pkg::S_SCAN: begin
                w_re    = r_scan_idx < r_fill;
                w_raddr = IW'(r_scan_idx);
            end
            fcht_pkg::S_WRITE: begin
                w_we = 1'b1;
                if (r_hit) begin
                    w_wdata = {r_req.suspect_number, r_req.failure_mode, r_req.source_addr,
                               r_hit_first, r_req.time_stamp, w_occ_next};
                end
            end
            fcht_pkg::S_READ,
            fcht_pkg::S_RESULT: ;
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fcht_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_fill      <= '0;
            r_act_cnt   <= '0;
            r_active    <= '0;
            r_chk_valid <= 1'b0;
            r_hit       <= 1'b0;
        end else begin
            r_state <= n_state;

            if ((r_state == fcht_pkg::S_RESULT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                fcht_pkg::S_IDLE: begin
                    if (w_accept) begin
                        r_req       <= i_req.payload;
                        r_scan_idx  <= '0;
                        r_chk_valid <= 1'b0;
                        r_hit       <= 1'b0;
                        r_res       <= w_res_init;
                        if (i_req.payload.opcode == fcht_pkg::OP_CLR_ACT) begin
                            r_active     <= '0;
                            r_act_cnt    <= '0;
                        end
                        if (i_req.payload.opcode == fcht_pkg::OP_CLR_ALL) begin
                            r_active     <= '0;
                            r_act_cnt    <= '0;
                            r_fill       <= '0;
                        end
                    end
                end
                fcht_pkg::S_SCAN: begin
                    r_chk_valid <= w_re;
                    r_chk_idx   <= IW'(r_scan_idx);
                    if (w_re) begin
                        r_scan_idx <= r_scan_idx + CW'(1);
                    end
                    if (r_chk_valid) begin
                        if (w_key_hit && !r_hit) begin
                            r_hit       <= 1'b1;
                            r_hit_idx   <= r_chk_idx;
                            r_hit_first <= m_first;
                            r_hit_occ   <= m_occ;
                        end
                        // strict less keeps the lowest index on a tie
                        if ((r_chk_idx == '0) || (m_last < r_min_last)) begin
                            r_min_last <= m_last;
                            r_min_idx  <= r_chk_idx;
                        end
                    end
                end
                fcht_pkg::S_WRITE: begin
                    r_chk_valid      <= 1'b0;
                    r_active[w_slot] <= r_req.active_in;
                    r_act_cnt        <= r_act_cnt - CW'(r_active[w_slot])
                                      + CW'(r_req.active_in);
                    if (w_status == fcht_pkg::ST_INSERTED) begin
                        r_fill <= r_fill + CW'(1);
                    end
                    r_res.status <= w_status;
                    r_res.slot   <= fcht_pkg::SLOT_W'(w_slot);
                end
                fcht_pkg::S_READ: begin
                    r_res.status <= fcht_pkg::ST_READ;
                    r_res.slot   <= r_req.read_index;
                    // entries at or beyond the fill level read as zero
                    if (w_ri_used) begin
                        r_res.rd_suspect_number <= m_sn;
                        r_res.rd_failure_mode   <= m_fm;
                        r_res.rd_source_addr    <= m_sa;
                        r_res.rd_first_seen     <= m_first;
                        r_res.rd_last_seen      <= m_last;
                        r_res.rd_occurrences    <= fcht_pkg::OCC_O_W'(m_occ);
                        r_res.rd_active         <= r_active[IW'(r_req.read_index)];
                    end
                end
                fcht_pkg::S_RESULT: begin
                    if (w_out_free) begin
                        r_out <= w_out;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

`ifndef SYNTHESIS
    a_act_le_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_act_cnt <= r_fill)
        else $error("active count exceeds fill level");

    a_fill_le_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= DEPTH_C)
        else $error("fill level beyond table depth");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (r_state != fcht_pkg::S_IDLE))
        else $error("request accepted but sequencer stayed idle");

    a_chk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == fcht_pkg::S_SCAN) && r_chk_valid) |-> (CW'(r_chk_idx) < r_fill))
        else $error("scan compared an unused entry");
`endif

endmodule

### rtl/fcht_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM, registered read, no reset on contents
module fcht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
